### rtl/bcrle_pkg.sv
// bcrle_pkg: request codes, field widths and limits shared by the bayer colour
// run-length encoder files. No dependencies.
`default_nettype none

package bcrle_pkg;

  // line geometry and table size
  localparam int unsigned MaxLinePairs = 512;
  localparam int unsigned TableDepth   = 65536;
  localparam int unsigned TableAw      = $clog2(TableDepth);

  // field widths
  localparam int unsigned SampleW  = 8;
  localparam int unsigned ModelW   = 3;
  localparam int unsigned ReqW     = 3;
  localparam int unsigned WordW    = 32;
  localparam int unsigned ColW     = $clog2(MaxLinePairs + 1);
  localparam int unsigned RunW     = $clog2(MaxLinePairs);
  localparam int unsigned StartFw  = 9;
  localparam int unsigned LengthFw = 20;

  localparam logic [WordW-1:0] LineStartWord = '0;
  localparam logic [WordW-1:0] FrameEndWord  = '1;

  typedef enum logic [ReqW-1:0] {
    ReqPixel      = 3'd0,
    ReqLineStart  = 3'd1,
    ReqLineEnd    = 3'd2,
    ReqFrameEnd   = 3'd3,
    ReqTableWrite = 3'd4
  } req_e;

  // request held after the table read, model comes from the table port
  typedef struct packed {
    logic              valid;
    logic [ReqW-1:0]   req;
    logic [ModelW-1:0] model;
  } stage_t;

endpackage

`default_nettype wire

### rtl/bcrle_if.sv
// bcrle_if: valid/ready channels of the bayer colour run-length encoder,
// request side and run word side. Depends on bcrle_pkg.
`default_nettype none

interface bcrle_req_if;
  logic                             valid;
  logic                             ready;
  logic [bcrle_pkg::ReqW-1:0]       req_type;
  logic [bcrle_pkg::SampleW-1:0]    red_sample;
  logic [bcrle_pkg::SampleW-1:0]    green_same_row;
  logic [bcrle_pkg::SampleW-1:0]    green_prev_row;
  logic [bcrle_pkg::SampleW-1:0]    blue_sample;
  logic [bcrle_pkg::TableAw-1:0]    table_index;
  logic [bcrle_pkg::ModelW-1:0]     table_model;

  modport source (
    output valid, req_type, red_sample, green_same_row, green_prev_row,
           blue_sample, table_index, table_model,
    input  ready
  );
  modport sink (
    input  valid, req_type, red_sample, green_same_row, green_prev_row,
           blue_sample, table_index, table_model,
    output ready
  );
endinterface

interface bcrle_run_if;
  logic                          valid;
  logic                          ready;
  logic [bcrle_pkg::WordW-1:0]   run_word;

  modport source (output valid, run_word, input ready);
  modport sink (input valid, run_word, output ready);
endinterface

`default_nettype wire

### rtl/bcrle_ram.sv
// bcrle_ram: generic single-port synchronous ram with registered read data.
// No dependencies.
`default_nettype none

module bcrle_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // read data holds while the port is idle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem_q[addr_i];
      end
    end
  end

endmodule

`default_nettype wire

### rtl/bcrle_run_ctrl.sv
// bcrle_run_ctrl: run tracking state, run word assembly and output register.
// Depends on bcrle_pkg and bcrle_if.
`default_nettype none

module bcrle_run_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bcrle_pkg::stage_t stage_i,
  output      logic              stage_ready_o,
  bcrle_run_if.source            run_o
);

  logic [bcrle_pkg::ModelW-1:0] prev_q, prev_d;
  logic [bcrle_pkg::RunW-1:0]   start_q, start_d;
  logic [bcrle_pkg::ColW-1:0]   col_q, col_d;
  logic                         out_valid_q;
  logic [bcrle_pkg::WordW-1:0]  out_word_q;

  logic                          out_free;
  logic                          fire;
  logic                          emit;
  logic [bcrle_pkg::WordW-1:0]   word;
  logic [bcrle_pkg::LengthFw-1:0] run_len;
  logic [bcrle_pkg::WordW-1:0]   run_word;

  assign out_free      = !out_valid_q || run_o.ready;
  assign stage_ready_o = out_free;
  assign fire          = stage_i.valid && out_free;

  assign run_len  = bcrle_pkg::LengthFw'(col_q) - bcrle_pkg::LengthFw'(start_q);
  assign run_word = {run_len, bcrle_pkg::StartFw'(start_q), prev_q};

  always_comb begin
    prev_d  = prev_q;
    start_d = start_q;
    col_d   = col_q;
    emit    = 1'b0;
    word    = run_word;
    case (bcrle_pkg::req_e'(stage_i.req))
      bcrle_pkg::ReqPixel: begin
        if (col_q < bcrle_pkg::ColW'(bcrle_pkg::MaxLinePairs)) begin
          col_d = col_q + 1'b1;
          if (prev_q != '0 && stage_i.model != prev_q) begin
            // model change closes the run, the changing pair is dropped
            emit    = 1'b1;
            prev_d  = '0;
            start_d = '0;
          end else begin
            if (stage_i.model != '0 && prev_q == '0) begin
              start_d = col_q[bcrle_pkg::RunW-1:0];
            end
            prev_d = stage_i.model;
          end
        end
      end
      bcrle_pkg::ReqLineStart: begin
        emit    = 1'b1;
        word    = bcrle_pkg::LineStartWord;
        prev_d  = '0;
        start_d = '0;
        col_d   = '0;
      end
      bcrle_pkg::ReqLineEnd: begin
        // flush only for a run that did not start at pair zero
        if (start_q != '0) begin
          emit    = 1'b1;
          prev_d  = '0;
          start_d = '0;
        end
      end
      bcrle_pkg::ReqFrameEnd: begin
        emit    = 1'b1;
        word    = bcrle_pkg::FrameEndWord;
        prev_d  = '0;
        start_d = '0;
        col_d   = '0;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      start_q     <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        prev_q  <= prev_d;
        start_q <= start_d;
        col_q   <= col_d;
      end
      if (out_free) begin
        out_valid_q <= fire && emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      out_word_q <= word;
    end
  end

  assign run_o.valid    = out_valid_q;
  assign run_o.run_word = out_word_q;

endmodule

`default_nettype wire

### rtl/bayer_color_run_length_encoder.sv
// bayer_color_run_length_encoder: top level, colour index forming, model table
// and run stage. Depends on bcrle_pkg, bcrle_if, bcrle_ram, bcrle_run_ctrl.
//
// usage
// - req_i carries one request per handshake: a pixel quad, line start, line
//   end, frame end or a table write (model number stored at table_index)
// - run_o carries 32-bit run words: model in bits 0-2, start pair in bits
//   3-11, length in pairs from bit 12; zero at line start, all ones at
//   frame end
// - the model table must be loaded by table writes before any pixel quad
//   looks it up; its contents are undefined after reset
// - throughput is one request per cycle unless the output side stalls, set by
//   the single table port: every request uses it once, either to write or to read
// - a run word is formed from the request that causes it by the table read,
//   then the run update into the output register
// - reset clears the run state (previous model, run start, pair column) and
//   empties the pipeline; no clearing pass, requests are taken at once
// - when the receiver stalls, the word waits in the output register and one
//   more request can be taken and parked after the table read; the request
//   side then stalls until the word leaves
// - a table write followed at once by a quad using that entry sees the new
//   model, since the write lands at its own acceptance edge
`default_nettype none

module bayer_color_run_length_encoder (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  bcrle_req_if.sink   req_i,
  bcrle_run_if.source run_o
);

  logic                              accept;
  logic                              is_write;
  logic [bcrle_pkg::SampleW:0]       diff_rg;
  logic [bcrle_pkg::SampleW:0]       diff_bg;
  logic [bcrle_pkg::TableAw-1:0]     pixel_index;
  logic [bcrle_pkg::TableAw-1:0]     ram_addr;
  logic [bcrle_pkg::ModelW-1:0]      ram_rdata;
  logic                              stage_ready;
  logic                              s1_valid_q;
  logic [bcrle_pkg::ReqW-1:0]        s1_req_q;
  bcrle_pkg::stage_t                 stage;

  // stage slot frees when empty or when the run stage takes it
  assign req_i.ready = !s1_valid_q || stage_ready;
  assign accept      = req_i.valid && req_i.ready;
  assign is_write    = bcrle_pkg::req_e'(req_i.req_type) == bcrle_pkg::ReqTableWrite;

  // 9-bit signed differences, halved toward minus infinity by dropping bit 0
  assign diff_rg = {1'b0, req_i.red_sample} - {1'b0, req_i.green_same_row};
  assign diff_bg = {1'b0, req_i.blue_sample} - {1'b0, req_i.green_prev_row};
  assign pixel_index = {diff_rg[bcrle_pkg::SampleW:1], diff_bg[bcrle_pkg::SampleW:1]};

  assign ram_addr = is_write ? req_i.table_index : pixel_index;

  bcrle_ram #(
    .Width (bcrle_pkg::ModelW),
    .Depth (bcrle_pkg::TableDepth)
  ) u_model_table (
    .clk_i   (clk_i),
    .en_i    (accept),
    .we_i    (is_write),
    .addr_i  (ram_addr),
    .wdata_i (req_i.table_model),
    .rdata_o (ram_rdata)
  );

  // request held alongside the table read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_req_q   <= bcrle_pkg::ReqPixel;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
      s1_req_q   <= req_i.req_type;
    end
  end

  assign stage.valid = s1_valid_q;
  assign stage.req   = s1_req_q;
  assign stage.model = ram_rdata;

  bcrle_run_ctrl u_run_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stage_i       (stage),
    .stage_ready_o (stage_ready),
    .run_o         (run_o)
  );

endmodule

`default_nettype wire

### tb/testbench.sv
// testbench: self-checking bench for the bayer colour run-length encoder, with
// randomised lines of colour runs, table loads and stalls on both channels.
// Depends on bcrle_pkg, bcrle_if and the bayer_color_run_length_encoder RTL.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bcrle_pkg::*;

  // request codes the block ignores
  localparam logic [ReqW-1:0] ReqSpareFirst = 3'd5;
  localparam logic [ReqW-1:0] ReqSpareLast  = 3'd7;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned RandomTarget = 500;
  localparam int unsigned LongLinePairs = MaxLinePairs + 20;
  localparam int unsigned StallAt      = 350;
  localparam int unsigned StallCycles  = 120;
  localparam int unsigned CalmFrom     = 150;
  localparam int unsigned CalmTo       = 300;
  localparam int unsigned MaxReported  = 10;

  typedef struct {
    logic [ReqW-1:0]    req;
    logic [SampleW-1:0] red;
    logic [SampleW-1:0] green_row;
    logic [SampleW-1:0] green_prev;
    logic [SampleW-1:0] blue;
    logic [TableAw-1:0] tab_index;
    logic [ModelW-1:0]  tab_model;
    bit                 drain;
  } quad_req_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bcrle_req_if req_if ();
  bcrle_run_if run_if ();

  bayer_color_run_length_encoder i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .run_o  (run_if)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // predictor state: its own copy of the table and the run tracking
  // ---------------------------------------------------------------------------
  logic [ModelW-1:0]  model_mem [TableDepth];
  logic [ModelW-1:0]  prev_model;
  logic [StartFw-1:0] run_first;
  logic [ColW-1:0]    pair_col;
  logic [WordW-1:0]   run_words_due [$];

  // stimulus bookkeeping
  quad_req_t pending_requests [$];
  quad_req_t colour_pool [$];
  bit        entry_loaded [TableDepth];
  int        requests_left;
  int        generated;

  // run-time counters
  int unsigned requests_taken;
  int unsigned cycles;
  int unsigned mismatches;
  int unsigned stall_left;
  bit          stall_done;
  quad_req_t   offered;

  // no idling on either side while this is set
  wire calm = (requests_taken >= CalmFrom) && (requests_taken < CalmTo);

  // table index of a quad: halved signed differences, low bytes packed
  function automatic logic [TableAw-1:0] colour_index(input quad_req_t q);
    logic signed [SampleW:0] diff_rg;
    logic signed [SampleW:0] diff_bg;
    logic signed [SampleW:0] half_rg;
    logic signed [SampleW:0] half_bg;
    diff_rg = $signed({1'b0, q.red})  - $signed({1'b0, q.green_row});
    diff_bg = $signed({1'b0, q.blue}) - $signed({1'b0, q.green_prev});
    half_rg = diff_rg >>> 1;
    half_bg = diff_bg >>> 1;
    return {half_rg[SampleW-1:0], half_bg[SampleW-1:0]};
  endfunction

  function automatic logic [WordW-1:0] pack_run(input logic [ModelW-1:0] model,
                                                input logic [StartFw-1:0] first,
                                                input logic [ColW-1:0] upto);
    logic [LengthFw-1:0] len;
    len = LengthFw'(upto) - LengthFw'(first);
    return {len, first, model};
  endfunction

  // works out the run word (if any) that an accepted request causes
  task automatic predict_run_words(input quad_req_t rq);
    logic [ModelW-1:0] model;
    case (rq.req)
      ReqPixel: begin
        if (pair_col < MaxLinePairs) begin
          model = model_mem[colour_index(rq)];
          if (model != '0 && prev_model == '0) run_first = pair_col[StartFw-1:0];
          if (prev_model != '0 && model != prev_model) begin
            // run closed, the quad at the change is dropped
            run_words_due.push_back(pack_run(prev_model, run_first, pair_col));
            prev_model = '0;
            run_first  = '0;
          end else begin
            prev_model = model;
          end
          pair_col = pair_col + 1'b1;
        end
      end
      ReqLineStart: begin
        prev_model = '0;
        run_first  = '0;
        pair_col   = '0;
        run_words_due.push_back(LineStartWord);
      end
      ReqLineEnd: begin
        // flush only when the run did not begin at pair 0
        if (run_first != '0) begin
          run_words_due.push_back(pack_run(prev_model, run_first, pair_col));
          prev_model = '0;
          run_first  = '0;
        end
      end
      ReqFrameEnd: begin
        prev_model = '0;
        run_first  = '0;
        pair_col   = '0;
        run_words_due.push_back(FrameEndWord);
      end
      ReqTableWrite: model_mem[rq.tab_index] = rq.tab_model;
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic quad_req_t noise_req(input logic [ReqW-1:0] code);
    quad_req_t rq;
    rq.req        = code;
    rq.red        = SampleW'($urandom);
    rq.green_row  = SampleW'($urandom);
    rq.green_prev = SampleW'($urandom);
    rq.blue       = SampleW'($urandom);
    rq.tab_index  = TableAw'($urandom);
    rq.tab_model  = ModelW'($urandom);
    rq.drain      = 1'b0;
    return rq;
  endfunction

  function automatic quad_req_t make_quad(input logic [SampleW-1:0] r, g1, g2, b);
    quad_req_t q;
    q            = noise_req(ReqPixel);
    q.red        = r;
    q.green_row  = g1;
    q.green_prev = g2;
    q.blue       = b;
    return q;
  endfunction

  // roughly a third of the colours map to no model, to break the runs
  function automatic logic [ModelW-1:0] pick_model();
    return ($urandom_range(9) < 3) ? '0 : ModelW'($urandom_range(7, 1));
  endfunction

  task automatic enqueue_request(input quad_req_t rq, input bit ignored);
    pending_requests.push_back(rq);
    requests_left++;
    if (!ignored && rq.req <= ReqTableWrite) generated++;
  endtask

  // table write for the quad's entry; the quad joins the colour pool
  task automatic load_quad(input quad_req_t q, input logic [ModelW-1:0] model);
    quad_req_t tw;
    tw           = noise_req(ReqTableWrite);
    tw.tab_index = colour_index(q);
    tw.tab_model = model;
    enqueue_request(tw, 1'b0);
    entry_loaded[tw.tab_index] = 1'b1;
    colour_pool.push_back(q);
  endtask

  task automatic new_pool_colour();
    quad_req_t q;
    q = noise_req(ReqPixel);
    if (entry_loaded[colour_index(q)]) colour_pool.push_back(q);
    else load_quad(q, pick_model());
  endtask

  // pixel request from a known colour, with fresh noise on the unused fields
  task automatic enqueue_quad(input quad_req_t q, input bit ignored);
    quad_req_t rq;
    rq            = noise_req(ReqPixel);
    rq.red        = q.red;
    rq.green_row  = q.green_row;
    rq.green_prev = q.green_prev;
    rq.blue       = q.blue;
    enqueue_request(rq, ignored);
  endtask

  // one line made of runs of repeated colours
  task automatic enqueue_line(input int pairs, input bit with_start, input bit with_end);
    quad_req_t q;
    quad_req_t tw;
    int        n;
    int        reps;
    n = 0;
    if (with_start) enqueue_request(noise_req(ReqLineStart), 1'b0);
    while (n < pairs) begin
      q    = colour_pool[$urandom_range(colour_pool.size() - 1)];
      reps = $urandom_range(8, 1);
      if ($urandom_range(99) < 5) begin
        // reload the entry right before the quad that reads it
        tw           = noise_req(ReqTableWrite);
        tw.tab_index = colour_index(q);
        tw.tab_model = pick_model();
        enqueue_request(tw, 1'b0);
      end
      for (int k = 0; k < reps && n < pairs; k++) begin
        enqueue_quad(q, n >= MaxLinePairs);
        n++;
      end
    end
    if (with_end) enqueue_request(noise_req(ReqLineEnd), 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // request driver: offers the next queued request, bar random gaps and drain holds, when the slot is free
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid          <= 1'b0;
      req_if.req_type       <= ReqPixel;
      req_if.red_sample     <= '0;
      req_if.green_same_row <= '0;
      req_if.green_prev_row <= '0;
      req_if.blue_sample    <= '0;
      req_if.table_index    <= '0;
      req_if.table_model    <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        predict_run_words(offered);
        requests_taken++;
        requests_left--;
      end
      if (!req_if.valid || req_if.ready) begin
        // a drain mark holds the request back until every run word is home
        if (pending_requests.size() != 0 && (calm || $urandom_range(99) >= 10) &&
            !(pending_requests[0].drain && run_words_due.size() != 0)) begin
          offered = pending_requests.pop_front();
          req_if.valid          <= 1'b1;
          req_if.req_type       <= offered.req;
          req_if.red_sample     <= offered.red;
          req_if.green_same_row <= offered.green_row;
          req_if.green_prev_row <= offered.green_prev;
          req_if.blue_sample    <= offered.blue;
          req_if.table_index    <= offered.tab_index;
          req_if.table_model    <= offered.tab_model;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, so the block fills up and stalls its request side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_left <= 0;
      stall_done <= 1'b0;
    end else if (!stall_done && requests_taken >= StallAt) begin
      stall_left <= StallCycles;
      stall_done <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_if.ready <= 1'b0;
    end else begin
      run_if.ready <= (stall_left == 0) && (calm || $urandom_range(99) >= 10);
    end
  end

  // ---------------------------------------------------------------------------
  // run word monitor: each word against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    logic [WordW-1:0] due;
    if (rst_ni && run_if.valid && run_if.ready) begin
      if (run_words_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported)
          $display("unexpected run word %h, none due", run_if.run_word);
      end else begin
        due = run_words_due.pop_front();
        if (run_if.run_word !== due) begin
          mismatches++;
          if (mismatches <= MaxReported)
            $display("run word mismatch: expected %h, got %h", due, run_if.run_word);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    quad_req_t qa;
    quad_req_t qb;
    quad_req_t qz;
    quad_req_t qneg;
    quad_req_t qmax;
    quad_req_t qmin;
    quad_req_t rq;
    quad_req_t tw;
    bit        long_done;
    int        pick;

    rst_ni         = 1'bx;
    rst_ni        <= 1'b0;
    requests_left  = 0;
    generated      = 0;
    requests_taken = 0;
    cycles         = 0;
    mismatches     = 0;
    prev_model     = '0;
    run_first      = '0;
    pair_col       = '0;
    long_done      = 1'b0;

    // directed: load a few colours, extremes of samples, index and model
    qa   = make_quad(8'd200, 8'd100, 8'd50,  8'd60);
    qb   = make_quad(8'd40,  8'd100, 8'd90,  8'd20);
    qz   = make_quad(8'd120, 8'd120, 8'd130, 8'd130);  // index 0
    qneg = make_quad(8'd10,  8'd11,  8'd11,  8'd10);   // index all ones
    qmax = make_quad(8'hff,  8'h00,  8'h00,  8'hff);
    qmin = make_quad(8'h00,  8'hff,  8'hff,  8'h00);
    load_quad(qa, 3'd3);
    load_quad(qb, 3'd5);
    load_quad(qz, 3'd0);
    load_quad(qneg, 3'd7);
    load_quad(qmax, 3'd6);
    load_quad(qmin, 3'd1);

    // pixel with no line start yet
    enqueue_quad(qa, 1'b0);
    enqueue_request(noise_req(ReqLineStart), 1'b0);
    // run of two, change of model drops a quad, run closed by a blank colour
    enqueue_quad(qa, 1'b0);
    enqueue_quad(qa, 1'b0);
    enqueue_quad(qb, 1'b0);
    enqueue_quad(qb, 1'b0);
    enqueue_quad(qb, 1'b0);
    enqueue_quad(qz, 1'b0);
    // run open at the line end is flushed once, a repeated line end is quiet
    enqueue_quad(qb, 1'b0);
    enqueue_request(noise_req(ReqLineEnd), 1'b0);
    enqueue_request(noise_req(ReqLineEnd), 1'b0);
    // run from pair 0 up to the line end is not flushed
    enqueue_request(noise_req(ReqLineStart), 1'b0);
    enqueue_quad(qmax, 1'b0);
    enqueue_quad(qmax, 1'b0);
    enqueue_request(noise_req(ReqLineEnd), 1'b0);
    enqueue_request(noise_req(ReqSpareFirst), 1'b1);
    enqueue_request(noise_req(ReqSpareLast), 1'b1);
    enqueue_quad(qneg, 1'b0);
    enqueue_quad(qmin, 1'b0);
    enqueue_request(noise_req(ReqFrameEnd), 1'b0);

    for (int k = 0; k < 12; k++) new_pool_colour();

    // random part, mostly well-formed lines
    generated = 0;
    while (generated < RandomTarget) begin
      pick = $urandom_range(99);
      if (!long_done && generated > 100) begin
        // one line past the pair limit, then a pause until all words are in
        enqueue_line(LongLinePairs, 1'b1, 1'b1);
        rq       = noise_req(ReqFrameEnd);
        rq.drain = 1'b1;
        enqueue_request(rq, 1'b0);
        long_done = 1'b1;
      end else if (pick < 65) begin
        enqueue_line($urandom_range(40, 1), $urandom_range(9) != 0,
                     $urandom_range(9) < 8);
      end else if (pick < 73) begin
        new_pool_colour();
      end else if (pick < 79) begin
        tw = noise_req(ReqTableWrite);
        entry_loaded[tw.tab_index] = 1'b1;
        enqueue_request(tw, 1'b0);
      end else if (pick < 83) begin
        enqueue_request(noise_req(ReqW'(ReqSpareFirst + $urandom_range(2))), 1'b1);
      end else if (pick < 89) begin
        enqueue_request(noise_req(ReqFrameEnd), 1'b0);
      end else if (pick < 95) begin
        enqueue_quad(colour_pool[$urandom_range(colour_pool.size() - 1)], 1'b0);
      end else begin
        enqueue_request(noise_req(ReqLineEnd), 1'b0);
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (requests_left != 0) @(posedge clk_i);
    while (run_words_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
